/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each use expands to one labelled
// concurrent assertion that is switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DCZS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DCZS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/dczs_pkg.sv */
// ----------------------------------------------------------------------------
// Draw command z-order sorter package
// Shared types, constants and the scissor arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package dczs_pkg;

	localparam int MAX_COMMANDS = 64;
	localparam int CNT_W        = 7;
	localparam int FIRST_W      = 22;
	localparam int PIX_W        = 15;

	typedef enum logic [1:0] {
		REG_VIEWPORT_SELECT = 2'd0,
		REG_WINDOW_WIDTH    = 2'd1,
		REG_WINDOW_HEIGHT   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_COUNT,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [PIX_W-1:0] origin;
		logic [PIX_W-1:0] size;
	} axis_t;

	typedef struct packed {
		logic [15:0]        z;
		logic [15:0]        count;
		logic [2:0]         viewport;
		logic [15:0]        texture;
		logic [FIRST_W-1:0] first;
		axis_t              sx;
		axis_t              sy;
	} cmd_rec_t;

	// Floor of the near edge, ceiling of the far edge, clamped to the window.
	function automatic axis_t make_axis(logic [19:0] edge_in, logic [18:0] len,
		logic [PIX_W-1:0] win);
		logic signed [21:0] ext;
		logic signed [21:0] lo;
		logic signed [21:0] far_e;
		logic signed [21:0] hi;
		logic signed [21:0] lim;
		logic signed [21:0] sz;
		axis_t              r;
		ext   = {{2{edge_in[19]}}, edge_in};
		lo    = ext >>> 4;
		far_e = ext + $signed({3'b000, len});
		hi    = (far_e + 22'sd15) >>> 4;
		lim   = $signed({7'b0000000, win});
		if (lo < 22'sd0) lo = 22'sd0;
		if (hi > lim) hi = lim;
		if (hi < lo) hi = lo;
		sz       = hi - lo;
		r.origin = lo[PIX_W-1:0];
		r.size   = sz[PIX_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/dczs_ifs.sv */
// ----------------------------------------------------------------------------
// Draw command z-order sorter channels
// Command, draw and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dczs_cmd_if;
	logic        valid;
	logic        ready;
	logic [15:0] command_z;
	logic [15:0] element_count;
	logic [2:0]  command_viewport;
	logic [19:0] clip_x;
	logic [19:0] clip_y;
	logic [18:0] clip_w;
	logic [18:0] clip_h;
	logic [15:0] texture_in;
	logic        last_command;

	modport source (output valid, command_z, element_count, command_viewport, clip_x,
		clip_y, clip_w, clip_h, texture_in, last_command, input ready);
	modport sink (input valid, command_z, element_count, command_viewport, clip_x,
		clip_y, clip_w, clip_h, texture_in, last_command, output ready);
endinterface

interface dczs_draw_if;
	logic        valid;
	logic        ready;
	logic        draw_valid;
	logic [21:0] start_index;
	logic [15:0] index_total;
	logic [15:0] texture_slot;
	logic [14:0] scissor_x;
	logic [14:0] scissor_y;
	logic [14:0] scissor_width;
	logic [14:0] scissor_height;
	logic [6:0]  frame_draw_count;
	logic [6:0]  peak_draw_count;
	logic        last_result;

	modport source (output valid, draw_valid, start_index, index_total, texture_slot,
		scissor_x, scissor_y, scissor_width, scissor_height, frame_draw_count,
		peak_draw_count, last_result, input ready);
	modport sink (input valid, draw_valid, start_index, index_total, texture_slot,
		scissor_x, scissor_y, scissor_width, scissor_height, frame_draw_count,
		peak_draw_count, last_result, output ready);
endinterface

interface dczs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [14:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/draw_command_z_order_sorter_top.sv */
// ----------------------------------------------------------------------------
// Draw command z-order sorter
// Stores a frame of draw commands and emits its draws stably sorted by z.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  cmd      in         one draw command per item, last_command closes the frame
//  draw     out        one draw (or the empty-frame marker) per item
//  cfg      in         register writes: viewport select, window width, height
//
// Commands are taken one per cycle while the block is loading; the first
// MAX_COMMANDS are written to the command memory with their prefix sums and
// scissors already worked out, and later ones are dropped. After the last
// command a counting pass reads every stored entry once, then each draw takes
// one selection pass over the memory's single read port followed by the
// output register. A frame with no draws yields only the empty-frame
// marker.
// No command is taken while a frame drains. Reset clears the control state
// only; the memory needs no clearing as only entries of the current frame are
// read. A stalled draw item simply holds the block in its output state.
// ----------------------------------------------------------------------------
`default_nettype none

module draw_command_z_order_sorter_top #(
	parameter int MAX_COMMANDS = dczs_pkg::MAX_COMMANDS
) (
	input  wire          clk,
	input  wire          arst_n,
	dczs_cmd_if.sink     cmd,
	dczs_draw_if.source  draw,
	dczs_cfg_if.sink     cfg
);

	localparam int IDX_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
	localparam int CNT_W = dczs_pkg::CNT_W;
	localparam int KEY_W = 16 + IDX_W;

	// Configuration registers.
	logic [2:0]                   viewport_select_q;
	logic [dczs_pkg::PIX_W-1:0]   window_width_q;
	logic [dczs_pkg::PIX_W-1:0]   window_height_q;

	// Frame control.
	dczs_pkg::state_t             state_q, state_d;
	logic [CNT_W-1:0]             loaded_q;
	logic [dczs_pkg::FIRST_W-1:0] running_first_q;
	logic [CNT_W-1:0]             draws_q;
	logic [CNT_W-1:0]             peak_q;
	logic [CNT_W-1:0]             emitted_q;

	// Memory walk.
	logic [CNT_W-1:0]             issue_q;
	logic                         rd_v_s1;
	logic                         rd_last_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	dczs_pkg::cmd_rec_t           rd_data_s1;

	// Selection state: the key of the draw last emitted and the best so far.
	logic                         have_prev_q;
	logic [KEY_W-1:0]             prev_key_q;
	logic                         found_q;
	logic [KEY_W-1:0]             best_key_q;
	dczs_pkg::cmd_rec_t           best_rec_q;

	// Output register.
	logic                         out_draw_valid_q;
	logic                         out_last_q;
	dczs_pkg::cmd_rec_t           out_rec_q;

	dczs_pkg::cmd_rec_t           mem [MAX_COMMANDS];

	logic                         cmd_accept;
	logic                         store_en;
	dczs_pkg::cmd_rec_t           wr_rec;
	logic                         issuing;
	logic                         walk_done;
	logic                         qualify;
	logic [KEY_W-1:0]             rd_key;
	logic                         cand;
	logic [CNT_W-1:0]             draws_total;
	logic [CNT_W-1:0]             emitted_next;
	logic                         draw_accept;

	assign cmd.ready   = (state_q == dczs_pkg::ST_LOAD);
	assign cmd_accept  = cmd.valid & cmd.ready;
	assign store_en    = cmd_accept && (loaded_q < CNT_W'(MAX_COMMANDS));
	assign cfg.ready   = 1'b1;
	assign draw_accept = draw.valid & draw.ready;

	// The scissor is fixed at load time with the window size then in force.
	always_comb begin
		wr_rec.z        = cmd.command_z;
		wr_rec.count    = cmd.element_count;
		wr_rec.viewport = cmd.command_viewport;
		wr_rec.texture  = cmd.texture_in;
		wr_rec.first    = running_first_q;
		wr_rec.sx       = dczs_pkg::make_axis(cmd.clip_x, cmd.clip_w, window_width_q);
		wr_rec.sy       = dczs_pkg::make_axis(cmd.clip_y, cmd.clip_h, window_height_q);
	end

	assign issuing = ((state_q == dczs_pkg::ST_COUNT) || (state_q == dczs_pkg::ST_SCAN))
		&& (issue_q < loaded_q);
	assign walk_done = rd_v_s1 && rd_last_s1;

	// A command counts as a draw if it has indices and belongs to the viewport.
	assign qualify     = (rd_data_s1.count != 16'd0) && (rd_data_s1.viewport == viewport_select_q);
	assign rd_key      = {rd_data_s1.z, rd_idx_s1};
	// Next in order: smallest (z, slot) key above the one emitted last.
	assign cand        = rd_v_s1 && qualify && (!have_prev_q || (rd_key > prev_key_q))
		&& (!found_q || (rd_key < best_key_q));
	assign draws_total = draws_q + CNT_W'(rd_v_s1 && qualify);
	assign emitted_next = emitted_q + CNT_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dczs_pkg::ST_LOAD: begin
				if (cmd_accept && cmd.last_command) state_d = dczs_pkg::ST_COUNT;
			end
			dczs_pkg::ST_COUNT: begin
				if (walk_done) begin
					state_d = (draws_total == '0) ? dczs_pkg::ST_OUT : dczs_pkg::ST_SCAN;
				end
			end
			dczs_pkg::ST_SCAN: begin
				if (walk_done) state_d = dczs_pkg::ST_OUT;
			end
			dczs_pkg::ST_OUT: begin
				if (draw.ready) state_d = out_last_q ? dczs_pkg::ST_LOAD : dczs_pkg::ST_SCAN;
			end
			default: state_d = dczs_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dczs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewport_select_q <= '0;
			window_width_q    <= '0;
			window_height_q   <= '0;
		end else if (cfg.valid) begin
			case (dczs_pkg::cfg_reg_t'(cfg.index))
				dczs_pkg::REG_VIEWPORT_SELECT: viewport_select_q <= cfg.data[2:0];
				dczs_pkg::REG_WINDOW_WIDTH:    window_width_q    <= cfg.data;
				dczs_pkg::REG_WINDOW_HEIGHT:   window_height_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Command memory: one write port for loading, one registered read port.
	always_ff @(posedge clk) begin
		if (store_en) mem[loaded_q[IDX_W-1:0]] <= wr_rec;
		rd_data_s1 <= mem[issue_q[IDX_W-1:0]];
		rd_idx_s1  <= issue_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q        <= '0;
			running_first_q <= '0;
			draws_q         <= '0;
			peak_q          <= '0;
			emitted_q       <= '0;
			issue_q         <= '0;
			rd_v_s1         <= 1'b0;
			rd_last_s1      <= 1'b0;
			have_prev_q     <= 1'b0;
			found_q         <= 1'b0;
		end else begin
			rd_v_s1    <= issuing;
			rd_last_s1 <= issuing && ((issue_q + CNT_W'(1)) == loaded_q);
			if (issuing) issue_q <= issue_q + CNT_W'(1);

			case (state_q)
				dczs_pkg::ST_LOAD: begin
					if (store_en) begin
						loaded_q        <= loaded_q + CNT_W'(1);
						running_first_q <= running_first_q
							+ dczs_pkg::FIRST_W'(cmd.element_count);
					end
					if (cmd_accept && cmd.last_command) begin
						issue_q     <= '0;
						draws_q     <= '0;
						emitted_q   <= '0;
						have_prev_q <= 1'b0;
						found_q     <= 1'b0;
					end
				end
				dczs_pkg::ST_COUNT: begin
					draws_q <= draws_total;
					if (walk_done) begin
						if (draws_total > peak_q) peak_q <= draws_total;
						issue_q <= '0;
						found_q <= 1'b0;
					end
				end
				dczs_pkg::ST_SCAN: begin
					if (cand) found_q <= 1'b1;
					if (walk_done) emitted_q <= emitted_next;
				end
				dczs_pkg::ST_OUT: begin
					if (draw.ready) begin
						if (out_last_q) begin
							loaded_q        <= '0;
							running_first_q <= '0;
						end else begin
							have_prev_q <= 1'b1;
							issue_q     <= '0;
							found_q     <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Selection and output payload registers.
	always_ff @(posedge clk) begin
		if (state_q == dczs_pkg::ST_OUT && draw.ready) prev_key_q <= best_key_q;
		if (state_q == dczs_pkg::ST_SCAN && cand) begin
			best_key_q <= rd_key;
			best_rec_q <= rd_data_s1;
		end
		if (state_q == dczs_pkg::ST_COUNT && walk_done && draws_total == '0) begin
			out_draw_valid_q <= 1'b0;
			out_last_q       <= 1'b1;
			out_rec_q        <= '0;
		end
		if (state_q == dczs_pkg::ST_SCAN && walk_done) begin
			out_draw_valid_q <= 1'b1;
			out_last_q       <= (emitted_next == draws_q);
			out_rec_q        <= cand ? rd_data_s1 : best_rec_q;
		end
	end

	assign draw.valid            = (state_q == dczs_pkg::ST_OUT);
	assign draw.draw_valid       = out_draw_valid_q;
	assign draw.start_index      = out_rec_q.first;
	assign draw.index_total      = out_rec_q.count;
	assign draw.texture_slot     = out_rec_q.texture;
	assign draw.scissor_x        = out_rec_q.sx.origin;
	assign draw.scissor_y        = out_rec_q.sy.origin;
	assign draw.scissor_width    = out_rec_q.sx.size;
	assign draw.scissor_height   = out_rec_q.sy.size;
	assign draw.frame_draw_count = draws_q;
	assign draw.peak_draw_count  = peak_q;
	assign draw.last_result      = out_last_q;

`include "assert_macros.svh"

	`DCZS_ASSERT_NOW(a_no_load_while_emit, clk, arst_n, draw.valid, !cmd.ready, "load during emission")
	`DCZS_ASSERT_NOW(a_count_below_peak, clk, arst_n, draw.valid, draws_q <= peak_q, "count above peak")
	`DCZS_ASSERT_NOW(a_loaded_in_range, clk, arst_n, 1'b1, loaded_q <= CNT_W'(MAX_COMMANDS), "store overrun")
	`DCZS_ASSERT_NEXT(a_frame_end_loads, clk, arst_n, draw_accept && draw.last_result, cmd.ready, "no reload after frame")

endmodule

`default_nettype wire

/* bench/tb_draw_command_z_order_sorter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw command z-order sorter testbench
// Drives frames of draw commands and register writes with random idle cycles
// on both channels. Every draw item is checked against a built-in predictor
// that stores each frame and stable-sorts it by z.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_draw_command_z_order_sorter_top;

	localparam int SLOTS      = dczs_pkg::MAX_COMMANDS;
	localparam int STALL_LIMIT = 20000;

	// One stimulus item, also used for the rows of the directed table.
	typedef struct {
		logic [15:0] z;
		logic [15:0] count;
		logic [2:0]  vp;
		logic [19:0] cx;
		logic [19:0] cy;
		logic [18:0] cw;
		logic [18:0] ch;
		logic [15:0] tex;
		logic        last;
	} command_t;

	// One expected draw item.
	typedef struct {
		logic        dv;
		logic [21:0] first;
		logic [15:0] count;
		logic [15:0] tex;
		logic [14:0] sx;
		logic [14:0] sy;
		logic [14:0] sw;
		logic [14:0] sh;
		logic [6:0]  fdc;
		logic [6:0]  peak;
		logic        last;
	} draw_t;

	logic clk;
	logic arst_n;

	dczs_cmd_if  cmd ();
	dczs_draw_if draw ();
	dczs_cfg_if  cfg ();

	draw_command_z_order_sorter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.draw   (draw.source),
		.cfg    (cfg.sink)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predictor state: register copies and the frame being collected.
	logic [2:0]  sel_vp;
	logic [14:0] win_w;
	logic [14:0] win_h;
	draw_t       frame_store[SLOTS];
	logic [15:0] frame_z[SLOTS];
	logic [2:0]  frame_vp[SLOTS];
	int          frame_len;
	logic [21:0] prefix_sum;
	int          peak_seen;

	draw_t pending_draws[$];
	int    fail_count;
	int    idle_pct;
	bit    stim_done;
	int    quiet_cycles;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// Floor of the near edge, ceiling of the far edge, clamp to window.
	function automatic void scissor_axis(input logic [19:0] edge_in, input logic [18:0] len,
		input logic [14:0] win, output logic [14:0] org, output logic [14:0] sz);
		longint e;
		longint lo;
		longint hi;
		e  = longint'($signed(edge_in));
		lo = (e >= 0) ? e / 16 : -((-e + 15) / 16);
		e  = e + longint'(len);
		hi = (e >= 0) ? (e + 15) / 16 : -((-e) / 16);
		if (lo < 0) lo = 0;
		if (hi > longint'(win)) hi = longint'(win);
		if (hi < lo) hi = lo;
		org = lo[14:0];
		sz  = 15'(hi - lo);
	endfunction

	// Loads one command into the frame store and, when it closes the frame,
	// queues the sorted draws it causes, or the empty-frame marker.
	task automatic predict_command(input command_t c);
		int    order[SLOTS];
		int    draws;
		int    k;
		int    b;
		draw_t d;
		if (frame_len < SLOTS) begin
			d       = '{default: '0};
			d.dv    = 1'b1;
			d.first = prefix_sum;
			d.count = c.count;
			d.tex   = c.tex;
			scissor_axis(c.cx, c.cw, win_w, d.sx, d.sw);
			scissor_axis(c.cy, c.ch, win_h, d.sy, d.sh);
			frame_store[frame_len] = d;
			frame_z[frame_len]     = c.z;
			frame_vp[frame_len]    = c.vp;
			prefix_sum             = prefix_sum + 22'(c.count);
			frame_len++;
		end
		if (!c.last)
			return;
		// Stable insertion sort by ascending z.
		for (int i = 0; i < frame_len; i++) begin
			b = i;
			while (b > 0 && frame_z[order[b-1]] > frame_z[i]) begin
				order[b] = order[b-1];
				b--;
			end
			order[b] = i;
		end
		draws = 0;
		for (int i = 0; i < frame_len; i++)
			if (frame_store[order[i]].count != 0 && frame_vp[order[i]] == sel_vp)
				draws++;
		if (draws > peak_seen)
			peak_seen = draws;
		if (draws == 0) begin
			d      = '{default: '0};
			d.peak = 7'(peak_seen);
			d.last = 1'b1;
			pending_draws.push_back(d);
		end else begin
			k = 0;
			for (int i = 0; i < frame_len; i++) begin
				d = frame_store[order[i]];
				if (d.count == 0 || frame_vp[order[i]] != sel_vp)
					continue;
				k++;
				d.fdc  = 7'(draws);
				d.peak = 7'(peak_seen);
				d.last = (k == draws);
				pending_draws.push_back(d);
			end
		end
		frame_len  = 0;
		prefix_sum = '0;
	endtask

	// Leaves valid high after the accepting edge; the next call, a register
	// write or the end of the stimulus replaces it or takes it down in that same step.
	task automatic send_command(input command_t c);
		while ($urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid            <= 1'b1;
		cmd.command_z        <= c.z;
		cmd.element_count    <= c.count;
		cmd.command_viewport <= c.vp;
		cmd.clip_x           <= c.cx;
		cmd.clip_y           <= c.cy;
		cmd.clip_w           <= c.cw;
		cmd.clip_h           <= c.ch;
		cmd.texture_in       <= c.tex;
		cmd.last_command     <= c.last;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		predict_command(c);
	endtask

	// Register writes happen only with nothing outstanding; the drain wait
	// covers a frame still being worked on after its last draw item.
	task automatic write_register(input dczs_pkg::cfg_reg_t idx, input logic [14:0] value);
		cmd.valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			dczs_pkg::REG_VIEWPORT_SELECT: begin
				sel_vp = value[2:0];
			end
			dczs_pkg::REG_WINDOW_WIDTH: begin
				win_w = value;
			end
			default: begin
				win_h = value;
			end
		endcase
	endtask

	function automatic command_t random_command(input bit closes);
		command_t c;
		c.z     = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
		c.count = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom);
		c.vp    = ($urandom_range(2) == 0) ? 3'($urandom) : sel_vp;
		c.cx    = 20'($urandom);
		c.cy    = 20'($urandom);
		c.cw    = 19'($urandom);
		c.ch    = 19'($urandom);
		if ($urandom_range(1)) begin
			c.cx = 20'($signed(12'($urandom)));
			c.cy = 20'($signed(12'($urandom)));
			c.cw = 19'($urandom_range(4000));
			c.ch = 19'($urandom_range(4000));
		end
		c.tex  = 16'($urandom);
		c.last = closes;
		return c;
	endfunction

	// Draw side: random stalls, comparison against the oldest expectation.
	always @(posedge clk) begin
		draw_t w;
		if (arst_n) begin
			if (draw.valid && draw.ready) begin
				if (pending_draws.size() == 0) begin
					report_mismatch("unexpected draw item", 1, 0);
				end else begin
					w = pending_draws.pop_front();
					if (draw.draw_valid !== w.dv)
						report_mismatch("draw_valid", draw.draw_valid, w.dv);
					if (draw.start_index !== w.first)
						report_mismatch("start_index", draw.start_index, w.first);
					if (draw.index_total !== w.count)
						report_mismatch("index_total", draw.index_total, w.count);
					if (draw.texture_slot !== w.tex)
						report_mismatch("texture_slot", draw.texture_slot, w.tex);
					if (draw.scissor_x !== w.sx)
						report_mismatch("scissor_x", draw.scissor_x, w.sx);
					if (draw.scissor_y !== w.sy)
						report_mismatch("scissor_y", draw.scissor_y, w.sy);
					if (draw.scissor_width !== w.sw)
						report_mismatch("scissor_width", draw.scissor_width, w.sw);
					if (draw.scissor_height !== w.sh)
						report_mismatch("scissor_height", draw.scissor_height, w.sh);
					if (draw.frame_draw_count !== w.fdc)
						report_mismatch("frame_draw_count", draw.frame_draw_count, w.fdc);
					if (draw.peak_draw_count !== w.peak)
						report_mismatch("peak_draw_count", draw.peak_draw_count, w.peak);
					if (draw.last_result !== w.last)
						report_mismatch("last_result", draw.last_result, w.last);
				end
			end
			draw.ready <= ($urandom_range(99) >= idle_pct);
		end else begin
			draw.ready <= 1'b0;
		end
	end

	// Watchdog: cycles in which no item moves on any channel.
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (draw.valid && draw.ready) ||
			(cfg.valid && cfg.ready) || !arst_n || (stim_done && pending_draws.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		// Directed frames. Expected items for the first two rows are built below;
		// every row goes to the predictor. All registers are zero on the first rows,
		// so every scissor has zero size; an origin past the window edge is kept.
		command_t directed[] = '{
			// Lone command with the largest count at reset settings.
			'{16'hFFFF, 16'hFFFF, 3'd0, 20'h7FFFF, 20'h80000, 19'h7FFFF, 19'h7FFFF, 16'hFFFF,
				1'b1},
			// Zero count only: empty-frame marker.
			'{16'd0, 16'd0, 3'd0, 20'd0, 20'd0, 19'd0, 19'd0, 16'd0, 1'b1},
			// Equal z runs and a command for another viewport.
			'{16'd5, 16'd3, 3'd0, 20'h00010, 20'h00008, 19'd100, 19'd37, 16'd1, 1'b0},
			'{16'd5, 16'd4, 3'd7, 20'hFFFF1, 20'hFFFF0, 19'd33, 19'd1, 16'd2, 1'b0},
			'{16'd1, 16'd2, 3'd0, 20'h80000, 20'h7FFFF, 19'd0, 19'd1, 16'd3, 1'b0},
			'{16'd5, 16'd0, 3'd0, 20'd0, 20'd0, 19'd16, 19'd16, 16'd4, 1'b0},
			'{16'd0, 16'd9, 3'd0, 20'd15, 20'd17, 19'd1, 19'd15, 16'd5, 1'b1}
		};
		draw_t marker;
		command_t c;
		int items;
		int flen;

		arst_n     = 1'b0;
		cmd.valid  = 1'b0;
		cmd.command_z = '0;
		cmd.element_count = '0;
		cmd.command_viewport = '0;
		cmd.clip_x = '0;
		cmd.clip_y = '0;
		cmd.clip_w = '0;
		cmd.clip_h = '0;
		cmd.texture_in = '0;
		cmd.last_command = 1'b0;
		cfg.valid  = 1'b0;
		cfg.index  = dczs_pkg::REG_VIEWPORT_SELECT;
		cfg.data   = '0;
		sel_vp = '0;
		win_w = '0;
		win_h = '0;
		frame_len = 0;
		prefix_sum = '0;
		peak_seen = 0;
		fail_count = 0;
		idle_pct = 24;
		stim_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first two rows are read straight off the rules. The left edge
		// of the first row floors to the largest origin.
		marker = '{1'b1, 22'd0, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'd0, 15'd0, 15'd0, 7'd1, 7'd1,
			1'b1};
		for (int i = 0; i < directed.size(); i++) begin
			if (i == 2) begin
				write_register(dczs_pkg::REG_WINDOW_WIDTH, 15'd16384);
				write_register(dczs_pkg::REG_WINDOW_HEIGHT, 15'd16384);
			end
			send_command(directed[i]);
			if (i == 0) begin
				// The predictor queued the same item; check it agrees.
				if (pending_draws[pending_draws.size()-1] != marker)
					report_mismatch("directed first draw", 0, 1);
			end
			if (i == 1) begin
				marker = '{1'b0, 22'd0, 16'd0, 16'd0, 15'd0, 15'd0, 15'd0, 15'd0, 7'd0, 7'd1,
					1'b1};
				if (pending_draws[pending_draws.size()-1] != marker)
					report_mismatch("directed empty marker", 0, 1);
			end
		end

		// Over capacity: a full frame with all draws, then dropped ones, the
		// last of which still closes the frame.
		for (int i = 0; i < SLOTS + 3; i++) begin
			c = random_command(i == SLOTS + 2);
			c.vp = sel_vp;
			c.count = 16'($urandom_range(1, 65535));
			send_command(c);
		end

		// Random frames through several register settings. The first stretch
		// has no idling at all.
		items = 0;
		for (int phase = 0; items < 336; phase++) begin
			idle_pct = (phase == 0) ? 0 : 24;
			case (phase % 4)
				0: begin
					write_register(dczs_pkg::REG_VIEWPORT_SELECT, 15'($urandom_range(7)));
				end
				1: begin
					write_register(dczs_pkg::REG_WINDOW_WIDTH, 15'($urandom_range(16384)));
					write_register(dczs_pkg::REG_WINDOW_HEIGHT, 15'($urandom_range(16384)));
				end
				2: begin
					write_register(dczs_pkg::REG_WINDOW_WIDTH, 15'd0);
					write_register(dczs_pkg::REG_VIEWPORT_SELECT, 15'd7);
				end
				default: begin
					write_register(dczs_pkg::REG_WINDOW_HEIGHT, 15'd16384);
					write_register(dczs_pkg::REG_WINDOW_WIDTH, 15'd16384);
				end
			endcase
			for (int f = 0; f < 4; f++) begin
				flen = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
				for (int i = 0; i < flen; i++) begin
					send_command(random_command(i == flen - 1));
					items++;
				end
			end
		end

		cmd.valid <= 1'b0;
		stim_done = 1'b1;
		while (pending_draws.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_draws.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
